// ===== rtl/core/fdq_pkg.sv =====
`timescale 1ns / 1ps

package fdq_pkg;

    // Defaults for the top-level parameters.
    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF    = 12;

    // Register fields fixed by the register map.
    localparam int MODE_BITS      = 4;
    localparam int CELL_SIZE_BITS = 31;
    localparam logic [CELL_SIZE_BITS-1:0] CELL_SIZE_RESET = 31'd65536;

    // Configuration register indexes.
    localparam logic CFG_QUANTITY_MODE = 1'b0;
    localparam logic CFG_CELL_SIZE     = 1'b1;

    // Quantity selection codes.
    localparam logic [MODE_BITS-1:0] MODE_COORD_X  = 4'd0;
    localparam logic [MODE_BITS-1:0] MODE_COORD_Y  = 4'd1;
    localparam logic [MODE_BITS-1:0] MODE_COORD_Z  = 4'd2;
    localparam logic [MODE_BITS-1:0] MODE_INDEX_X  = 4'd3;
    localparam logic [MODE_BITS-1:0] MODE_INDEX_Y  = 4'd4;
    localparam logic [MODE_BITS-1:0] MODE_INDEX_Z  = 4'd5;
    localparam logic [MODE_BITS-1:0] MODE_VEL_MAG  = 4'd6;
    localparam logic [MODE_BITS-1:0] MODE_KIN_VISC = 4'd7;
    localparam logic [MODE_BITS-1:0] MODE_STRAIN   = 4'd8;
    localparam logic [MODE_BITS-1:0] MODE_VORT     = 4'd9;
    localparam logic [MODE_BITS-1:0] MODE_Q_CRIT   = 4'd10;
    localparam logic [MODE_BITS-1:0] MODE_FLAME    = 4'd11;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDIV = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    // Which unit produces the final value of a request.
    typedef enum logic [1:0] {
        CLS_DIRECT,
        CLS_SQRT,
        CLS_DIV
    } fdq_class_t;

    typedef struct packed {
        fdq_class_t cls;
        logic       neg;
        logic       dz;
        logic       dov;
        logic [1:0] dstat;
    } fdq_ctl_t;

endpackage

// ===== rtl/core/fdq_front.sv =====
`timescale 1ns / 1ps

module fdq_front
    import fdq_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [MODE_BITS-1:0]              mode,
    input  logic [CELL_SIZE_BITS-1:0]         cell_size,
    input  logic [INDEX_BITS-1:0]             cell_i,
    input  logic [INDEX_BITS-1:0]             cell_j,
    input  logic [INDEX_BITS-1:0]             cell_k,
    input  logic signed [OPERAND_WIDTH-1:0]   g [9],
    output logic                              out_valid,
    output logic [MODE_BITS-1:0]              out_mode,
    output logic signed [2*OPERAND_WIDTH+3:0] p [6]
);

    localparam int MW = OPERAND_WIDTH + 2;
    localparam int PW = 2 * MW;
    localparam logic signed [MW-1:0] ONE_FRAC = MW'(1) << FRACTION_BITS;

    logic signed [MW-1:0] ge [9];
    logic signed [MW-1:0] a_next [6];
    logic signed [MW-1:0] b_next [6];
    logic signed [MW-1:0] a_reg [6];
    logic signed [MW-1:0] b_reg [6];
    logic signed [PW-1:0] p_reg [6];
    logic [INDEX_BITS-1:0] idx_sel;
    logic                 v1_reg;
    logic                 v2_reg;
    logic [MODE_BITS-1:0] mode1_reg;
    logic [MODE_BITS-1:0] mode2_reg;

    always_comb begin
        for (int n = 0; n < 9; n++) begin
            ge[n] = MW'(g[n]);
        end
    end

    always_comb begin
        unique case (mode) inside
            MODE_COORD_X, MODE_INDEX_X: idx_sel = cell_i;
            MODE_COORD_Y, MODE_INDEX_Y: idx_sel = cell_j;
            default:                    idx_sel = cell_k;
        endcase
    end

    // Each mode loads the six multiplier lanes with its own operand pairs.
    always_comb begin
        for (int n = 0; n < 6; n++) begin
            a_next[n] = '0;
            b_next[n] = '0;
        end
        unique case (mode) inside
            MODE_COORD_X, MODE_COORD_Y, MODE_COORD_Z: begin
                a_next[0] = MW'({idx_sel, 1'b1});
                b_next[0] = MW'(cell_size);
            end
            MODE_INDEX_X, MODE_INDEX_Y, MODE_INDEX_Z: begin
                a_next[0] = MW'(idx_sel);
                b_next[0] = ONE_FRAC;
            end
            MODE_VEL_MAG: begin
                for (int n = 0; n < 3; n++) begin
                    a_next[n] = ge[n];
                    b_next[n] = ge[n];
                end
            end
            MODE_KIN_VISC: begin
                a_next[0] = ge[0];
                b_next[0] = MW'(1);
                a_next[3] = ge[1];
                b_next[3] = MW'(1);
            end
            MODE_STRAIN, MODE_VORT: begin
                if (mode == MODE_STRAIN) begin
                    a_next[0] = ge[0];
                    b_next[0] = ge[0];
                    a_next[1] = ge[4];
                    b_next[1] = ge[4];
                    a_next[2] = ge[8];
                    b_next[2] = ge[8];
                    a_next[3] = ge[1] + ge[3];
                    a_next[4] = ge[2] + ge[6];
                    a_next[5] = ge[5] + ge[7];
                end else begin
                    a_next[3] = ge[1] - ge[3];
                    a_next[4] = ge[2] - ge[6];
                    a_next[5] = ge[5] - ge[7];
                end
                b_next[3] = a_next[3];
                b_next[4] = a_next[4];
                b_next[5] = a_next[5];
            end
            MODE_Q_CRIT: begin
                a_next[0] = ge[1];
                b_next[0] = ge[3];
                a_next[1] = ge[2];
                b_next[1] = ge[6];
                a_next[2] = ge[5];
                b_next[2] = ge[7];
                a_next[3] = ge[0];
                b_next[3] = ge[0];
                a_next[4] = ge[4];
                b_next[4] = ge[4];
                a_next[5] = ge[8];
                b_next[5] = ge[8];
            end
            MODE_FLAME: begin
                for (int n = 0; n < 3; n++) begin
                    a_next[n] = ge[n];
                    b_next[n] = ge[4+n];
                end
                a_next[3] = ge[3];
                b_next[3] = ge[7];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= mode;
            mode2_reg <= mode1_reg;
            for (int n = 0; n < 6; n++) begin
                a_reg[n] <= a_next[n];
                b_reg[n] <= b_next[n];
                p_reg[n] <= PW'(a_reg[n]) * PW'(b_reg[n]);
            end
        end
    end

    assign out_valid = v2_reg;
    assign out_mode  = mode2_reg;
    assign p         = p_reg;

endmodule

// ===== rtl/core/fdq_combine.sv =====
`timescale 1ns / 1ps

module fdq_combine
    import fdq_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [MODE_BITS-1:0]              mode,
    input  logic signed [2*OPERAND_WIDTH+3:0] p [6],
    output logic                              out_valid,
    output fdq_ctl_t                          out_ctl,
    output logic [OPERAND_WIDTH-1:0]          out_dval,
    output logic [2*OPERAND_WIDTH-1:0]        out_rad,
    output logic [2*OPERAND_WIDTH-2:0]        out_dr,
    output logic [OPERAND_WIDTH:0]            out_dn,
    output logic [2*OPERAND_WIDTH-2:0]        out_dd
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = 2 * W + 7;
    localparam int RW = 2 * W;
    localparam int QB = W + 1;
    localparam int XW = 2 * W + FRACTION_BITS;
    localparam logic signed [CW-1:0] POS_MAX = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [CW-1:0] NEG_MIN = {{(CW-W+1){1'b1}}, {(W-1){1'b0}}};

    logic                 v1_reg;
    logic [MODE_BITS-1:0] mode1_reg;
    logic signed [CW-1:0] s012_reg;
    logic signed [CW-1:0] s345_reg;
    logic signed [CW-1:0] p0_reg;
    logic signed [CW-1:0] p3_reg;

    logic signed [CW-1:0] rad_full;
    logic signed [CW-1:0] q_full;
    logic signed [CW-1:0] direct_full;
    logic signed [CW-1:0] s_abs;
    logic signed [CW-1:0] den_abs;
    logic [2*W-1:0]       num;
    logic [XW-1:0]        num_sh;
    logic [XW-1:0]        num_top;
    fdq_ctl_t             ctl_next;
    logic [W-1:0]         dval_next;
    logic [RW-1:0]        rad_next;
    logic [2*W-2:0]       dd_next;

    logic                 v2_reg;
    fdq_ctl_t             ctl_reg;
    logic [W-1:0]         dval_reg;
    logic [RW-1:0]        rad_reg;
    logic [2*W-2:0]       dr_reg;
    logic [QB-1:0]        dn_reg;
    logic [2*W-2:0]       dd_reg;

    always_comb begin
        unique case (mode1_reg) inside
            MODE_STRAIN: rad_full = (s012_reg <<< 1) + s345_reg;
            MODE_VORT:   rad_full = s345_reg;
            default:     rad_full = s012_reg;
        endcase
        rad_next = (rad_full[CW-1:RW] != '0) ? '1 : rad_full[RW-1:0];

        q_full = (-s345_reg - (s012_reg <<< 1)) >>> FRACTION_BITS;

        ctl_next = '0;
        unique case (mode1_reg) inside
            MODE_COORD_X, MODE_COORD_Y, MODE_COORD_Z: direct_full = p0_reg >>> 1;
            MODE_INDEX_X, MODE_INDEX_Y, MODE_INDEX_Z: direct_full = p0_reg;
            MODE_Q_CRIT:                              direct_full = q_full;
            default:                                  direct_full = '0;
        endcase
        if (direct_full > POS_MAX) begin
            dval_next      = POS_MAX[W-1:0];
            ctl_next.dstat = ST_SAT;
        end else if (direct_full < NEG_MIN) begin
            dval_next      = NEG_MIN[W-1:0];
            ctl_next.dstat = ST_SAT;
        end else begin
            dval_next      = direct_full[W-1:0];
            ctl_next.dstat = ST_OK;
        end

        unique case (mode1_reg) inside
            MODE_VEL_MAG, MODE_STRAIN, MODE_VORT: ctl_next.cls = CLS_SQRT;
            MODE_KIN_VISC, MODE_FLAME:            ctl_next.cls = CLS_DIV;
            default:                              ctl_next.cls = CLS_DIRECT;
        endcase

        // The quotient is formed on magnitudes; the sign is applied at the end.
        s_abs   = s012_reg[CW-1] ? -s012_reg : s012_reg;
        den_abs = p3_reg[CW-1] ? -p3_reg : p3_reg;
        num     = s_abs[2*W-1:0];
        dd_next = den_abs[2*W-2:0];
        num_sh  = {num, {FRACTION_BITS{1'b0}}};
        num_top = num_sh >> QB;
        ctl_next.neg = s012_reg[CW-1] ^ p3_reg[CW-1];
        ctl_next.dz  = (dd_next == '0);
        ctl_next.dov = (num_top >= XW'(dd_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= mode;
            s012_reg  <= CW'(p[0]) + CW'(p[1]) + CW'(p[2]);
            s345_reg  <= CW'(p[3]) + CW'(p[4]) + CW'(p[5]);
            p0_reg    <= CW'(p[0]);
            p3_reg    <= CW'(p[3]);
            ctl_reg   <= ctl_next;
            dval_reg  <= dval_next;
            rad_reg   <= rad_next;
            dr_reg    <= num_top[2*W-2:0];
            dn_reg    <= num_sh[QB-1:0];
            dd_reg    <= dd_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_ctl   = ctl_reg;
    assign out_dval  = dval_reg;
    assign out_rad   = rad_reg;
    assign out_dr    = dr_reg;
    assign out_dn    = dn_reg;
    assign out_dd    = dd_reg;

endmodule

// ===== rtl/core/fdq_step.sv =====
`timescale 1ns / 1ps

module fdq_step
    import fdq_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    parameter int STAGE         = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  fdq_ctl_t                   in_ctl,
    input  logic [OPERAND_WIDTH-1:0]   in_dval,
    input  logic [2*OPERAND_WIDTH-1:0] in_x,
    input  logic [OPERAND_WIDTH+2:0]   in_sr,
    input  logic [OPERAND_WIDTH-1:0]   in_sq,
    input  logic [2*OPERAND_WIDTH-2:0] in_dr,
    input  logic [OPERAND_WIDTH:0]     in_dn,
    input  logic [OPERAND_WIDTH:0]     in_dq,
    input  logic [2*OPERAND_WIDTH-2:0] in_dd,
    output logic                       out_valid,
    output fdq_ctl_t                   out_ctl,
    output logic [OPERAND_WIDTH-1:0]   out_dval,
    output logic [2*OPERAND_WIDTH-1:0] out_x,
    output logic [OPERAND_WIDTH+2:0]   out_sr,
    output logic [OPERAND_WIDTH-1:0]   out_sq,
    output logic [2*OPERAND_WIDTH-2:0] out_dr,
    output logic [OPERAND_WIDTH:0]     out_dn,
    output logic [OPERAND_WIDTH:0]     out_dq,
    output logic [2*OPERAND_WIDTH-2:0] out_dd
);

    localparam int W   = OPERAND_WIDTH;
    localparam int RW  = 2 * W;
    localparam int SRW = W + 3;
    localparam int QB  = W + 1;

    logic [RW-1:0]  x_next;
    logic [SRW-1:0] sr_next;
    logic [W-1:0]   sq_next;
    logic [2*W-2:0] dr_next;
    logic [QB-1:0]  dn_next;
    logic [QB-1:0]  dq_next;

    logic           valid_reg;
    fdq_ctl_t       ctl_reg;
    logic [W-1:0]   dval_reg;
    logic [RW-1:0]  x_reg;
    logic [SRW-1:0] sr_reg;
    logic [W-1:0]   sq_reg;
    logic [2*W-2:0] dr_reg;
    logic [QB-1:0]  dn_reg;
    logic [QB-1:0]  dq_reg;
    logic [2*W-2:0] dd_reg;

    // Up to two root digits and up to two quotient bits per stage.
    always_comb begin
        logic [SRW-1:0] r2;
        logic [SRW-1:0] trial;
        logic [2*W-1:0] rr;
        x_next  = in_x;
        sr_next = in_sr;
        sq_next = in_sq;
        dr_next = in_dr;
        dn_next = in_dn;
        dq_next = in_dq;
        for (int t = 0; t < 2; t++) begin
            if (2 * STAGE + t < W) begin
                r2    = {sr_next[SRW-3:0], x_next[RW-1:RW-2]};
                trial = SRW'({sq_next, 2'b01});
                if (r2 >= trial) begin
                    sr_next = r2 - trial;
                    sq_next = {sq_next[W-2:0], 1'b1};
                end else begin
                    sr_next = r2;
                    sq_next = {sq_next[W-2:0], 1'b0};
                end
                x_next = {x_next[RW-3:0], 2'b00};
            end
            if (2 * STAGE + t < QB) begin
                rr = {dr_next, dn_next[QB-1]};
                if (rr >= {1'b0, in_dd}) begin
                    rr      = rr - {1'b0, in_dd};
                    dq_next = {dq_next[QB-2:0], 1'b1};
                end else begin
                    dq_next = {dq_next[QB-2:0], 1'b0};
                end
                dr_next = rr[2*W-2:0];
                dn_next = {dn_next[QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg  <= in_ctl;
            dval_reg <= in_dval;
            x_reg    <= x_next;
            sr_reg   <= sr_next;
            sq_reg   <= sq_next;
            dr_reg   <= dr_next;
            dn_reg   <= dn_next;
            dq_reg   <= dq_next;
            dd_reg   <= in_dd;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_dval  = dval_reg;
    assign out_x     = x_reg;
    assign out_sr    = sr_reg;
    assign out_sq    = sq_reg;
    assign out_dr    = dr_reg;
    assign out_dn    = dn_reg;
    assign out_dq    = dq_reg;
    assign out_dd    = dd_reg;

endmodule

// ===== rtl/core/fdq_finish.sv =====
`timescale 1ns / 1ps

module fdq_finish
    import fdq_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  fdq_ctl_t                 in_ctl,
    input  logic [OPERAND_WIDTH-1:0] in_dval,
    input  logic [OPERAND_WIDTH-1:0] in_sq,
    input  logic [OPERAND_WIDTH:0]   in_dq,
    output logic                     out_valid,
    output logic [OPERAND_WIDTH-1:0] out_value,
    output logic [1:0]               out_status
);

    localparam int W  = OPERAND_WIDTH;
    localparam int QB = W + 1;
    localparam logic [W-1:0]  POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  NEG_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [QB-1:0] Q_POS   = {2'b00, {(W-1){1'b1}}};
    localparam logic [QB-1:0] Q_NEG   = {2'b01, {(W-1){1'b0}}};

    logic         valid_reg;
    logic [W-1:0] value_reg;
    logic [1:0]   status_reg;
    logic [W-1:0] value_next;
    logic [1:0]   status_next;
    logic [QB-1:0] q_neg;

    always_comb begin
        q_neg = ~in_dq + QB'(1);
        unique case (in_ctl.cls)
            CLS_SQRT: begin
                if (in_sq[W-1]) begin
                    value_next  = POS_MAX;
                    status_next = ST_SAT;
                end else begin
                    value_next  = in_sq;
                    status_next = ST_OK;
                end
            end
            CLS_DIV: begin
                if (in_ctl.dz) begin
                    value_next  = '0;
                    status_next = ST_ZDIV;
                end else if (in_ctl.dov || (in_ctl.neg ? (in_dq > Q_NEG) : (in_dq > Q_POS))) begin
                    value_next  = in_ctl.neg ? NEG_MIN : POS_MAX;
                    status_next = ST_SAT;
                end else begin
                    value_next  = in_ctl.neg ? q_neg[W-1:0] : in_dq[W-1:0];
                    status_next = ST_OK;
                end
            end
            default: begin
                value_next  = in_dval;
                status_next = in_ctl.dstat;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_value  = value_reg;
    assign out_status = status_reg;

endmodule

// ===== rtl/core/flow_derived_quantity_unit.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle; the pipeline advances as one while the output is free.
// The rate is set by the shared pipeline; the root and divide chain resolves up to two bits a stage.
// Reset (aresetn low, synchronous) clears all valid bits, sets quantity_mode to 0 and
// cell_size to 1.0 in Q15.16.

module flow_derived_quantity_unit
    import fdq_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int INDEX_BITS    = INDEX_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [CELL_SIZE_BITS-1:0]       cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [INDEX_BITS-1:0]           s_cell_i,
    input  logic [INDEX_BITS-1:0]           s_cell_j,
    input  logic [INDEX_BITS-1:0]           s_cell_k,
    input  logic signed [OPERAND_WIDTH-1:0] s_operand_0,
    input  logic signed [OPERAND_WIDTH-1:0] s_operand_1,
    input  logic signed [OPERAND_WIDTH-1:0] s_operand_2,
    input  logic signed [OPERAND_WIDTH-1:0] s_operand_3,
    input  logic signed [OPERAND_WIDTH-1:0] s_operand_4,
    input  logic signed [OPERAND_WIDTH-1:0] s_operand_5,
    input  logic signed [OPERAND_WIDTH-1:0] s_operand_6,
    input  logic signed [OPERAND_WIDTH-1:0] s_operand_7,
    input  logic signed [OPERAND_WIDTH-1:0] s_operand_8,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [OPERAND_WIDTH-1:0] m_quantity_value,
    output logic [1:0]                      m_result_status
);

    localparam int W  = OPERAND_WIDTH;
    localparam int RW = 2 * W;
    localparam int QB = W + 1;
    // Number of two-bit root and divide stages.
    localparam int NS = (W + 2) / 2;

    // Configuration registers. Writes are always taken; issue them only while the pipeline
    // is empty, as the block does not enforce it. Each request samples the mode as it enters.
    logic [MODE_BITS-1:0]      mode_reg;
    logic [CELL_SIZE_BITS-1:0] cell_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_COORD_X;
            cell_size_reg <= CELL_SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_QUANTITY_MODE: mode_reg      <= cfg_data[MODE_BITS-1:0];
                CFG_CELL_SIZE:     cell_size_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together. A request enters whenever the output register is
    // empty or its result is being taken in the same cycle, so a stall holds every stage.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic signed [W-1:0] g [9];
    assign g[0] = s_operand_0;
    assign g[1] = s_operand_1;
    assign g[2] = s_operand_2;
    assign g[3] = s_operand_3;
    assign g[4] = s_operand_4;
    assign g[5] = s_operand_5;
    assign g[6] = s_operand_6;
    assign g[7] = s_operand_7;
    assign g[8] = s_operand_8;

    // Stages one and two: operand selection for six multiplier lanes, then the products.
    logic                     fr_valid;
    logic [MODE_BITS-1:0]     fr_mode;
    logic signed [2*W+3:0]    fr_p [6];

    fdq_front #(
        .OPERAND_WIDTH(OPERAND_WIDTH),
        .FRACTION_BITS(FRACTION_BITS),
        .INDEX_BITS   (INDEX_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid && s_ready),
        .mode     (mode_reg),
        .cell_size(cell_size_reg),
        .cell_i   (s_cell_i),
        .cell_j   (s_cell_j),
        .cell_k   (s_cell_k),
        .g        (g),
        .out_valid(fr_valid),
        .out_mode (fr_mode),
        .p        (fr_p)
    );

    // Stage arrays for the root and divide chain; index 0 is fed by the combine stages.
    logic           st_valid [NS+1];
    fdq_ctl_t       st_ctl   [NS+1];
    logic [W-1:0]   st_dval  [NS+1];
    logic [RW-1:0]  st_x     [NS+1];
    logic [W+2:0]   st_sr    [NS+1];
    logic [W-1:0]   st_sq    [NS+1];
    logic [2*W-2:0] st_dr    [NS+1];
    logic [QB-1:0]  st_dn    [NS+1];
    logic [QB-1:0]  st_dq    [NS+1];
    logic [2*W-2:0] st_dd    [NS+1];

    // Stages three and four: sums of the products, the direct quantities with their
    // saturation, the root radicand, and the dividend and divisor of the quotient modes.
    fdq_combine #(
        .OPERAND_WIDTH(OPERAND_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_combine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (fr_valid),
        .mode     (fr_mode),
        .p        (fr_p),
        .out_valid(st_valid[0]),
        .out_ctl  (st_ctl[0]),
        .out_dval (st_dval[0]),
        .out_rad  (st_x[0]),
        .out_dr   (st_dr[0]),
        .out_dn   (st_dn[0]),
        .out_dd   (st_dd[0])
    );

    // The root and the quotient both start from zero.
    assign st_sr[0] = '0;
    assign st_sq[0] = '0;
    assign st_dq[0] = '0;

    // Digit-recurrence stages: each one holds up to two square-root digits and up to two restoring
    // division steps, so the root and the quotient leave the chain in the same pipeline slot.
    for (genvar s = 0; s < NS; s++) begin : g_step
        fdq_step #(
            .OPERAND_WIDTH(OPERAND_WIDTH),
            .STAGE        (s)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (st_valid[s]),
            .in_ctl   (st_ctl[s]),
            .in_dval  (st_dval[s]),
            .in_x     (st_x[s]),
            .in_sr    (st_sr[s]),
            .in_sq    (st_sq[s]),
            .in_dr    (st_dr[s]),
            .in_dn    (st_dn[s]),
            .in_dq    (st_dq[s]),
            .in_dd    (st_dd[s]),
            .out_valid(st_valid[s+1]),
            .out_ctl  (st_ctl[s+1]),
            .out_dval (st_dval[s+1]),
            .out_x    (st_x[s+1]),
            .out_sr   (st_sr[s+1]),
            .out_sq   (st_sq[s+1]),
            .out_dr   (st_dr[s+1]),
            .out_dn   (st_dn[s+1]),
            .out_dq   (st_dq[s+1]),
            .out_dd   (st_dd[s+1])
        );
    end

    // Final stage: picks the direct value, the root or the signed quotient, applies the
    // zero-divisor and saturation rules, and serves as the output register.
    logic [W-1:0] out_value;

    fdq_finish #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (st_valid[NS]),
        .in_ctl    (st_ctl[NS]),
        .in_dval   (st_dval[NS]),
        .in_sq     (st_sq[NS]),
        .in_dq     (st_dq[NS]),
        .out_valid (m_valid),
        .out_value (out_value),
        .out_status(m_result_status)
    );

    assign m_quantity_value = out_value;

    // A zero divisor always reports a zero value.
    a_zdiv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_status == ST_ZDIV) |-> (m_quantity_value == '0))
        else $error("zero-divisor result with nonzero value");

    // A saturated result sits on one of the two range bounds.
    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_status == ST_SAT) |->
        (m_quantity_value == {1'b0, {(W-1){1'b1}}} ||
         m_quantity_value == {1'b1, {(W-1){1'b0}}}))
        else $error("saturated result is not at a range bound");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule
